// ===== hw/rtl/gspc_pkg.sv =====
// shared types and constants of the group/species presence counter
`timescale 1ns / 1ps
`default_nettype none

package gspc_pkg;

    // field widths
    localparam int CmdW      = 2;
    localparam int GroupW    = 4;
    localparam int SpeciesW  = 8;
    localparam int ValueW    = 8;
    localparam int CountW    = 16;
    localparam int StatusW   = 2;
    localparam int AddrW     = GroupW + SpeciesW;
    localparam int CellCount = 1 << AddrW;

    // packed stream widths, padded to whole bytes
    localparam int InFieldsW = GroupW + SpeciesW + ValueW;
    localparam int InDataW   = ((InFieldsW + 7) / 8) * 8;
    localparam int OutDataW  = ((2 * CountW + 7) / 8) * 8;

    // configuration port
    localparam int CfgIdxW  = 1;
    localparam int GroupsW  = GroupW + 1;
    localparam int SpeciesLimW = SpeciesW + 1;
    localparam int CfgDataW = SpeciesLimW;
    localparam logic [GroupsW-1:0]     GroupsReset  = GroupsW'(1 << GroupW);
    localparam logic [SpeciesLimW-1:0] SpeciesReset = SpeciesLimW'(1 << SpeciesW);

    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [ValueW-1:0] ValPresent = ValueW'(1);
    localparam logic [ValueW-1:0] ValAbsent  = ValueW'(0);

    typedef enum logic [CfgIdxW-1:0] {
        REG_GROUPS  = 1'b0,
        REG_SPECIES = 1'b1
    } t_cfg_reg;

    typedef enum logic [CmdW-1:0] {
        CMD_ACC        = 2'd0,
        CMD_READ       = 2'd1,
        CMD_READ_CLEAR = 2'd2,
        CMD_READ_ALT   = 2'd3
    } t_cmd;

    typedef enum logic [StatusW-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    // operation decided by the front end
    typedef enum logic [2:0] {
        OP_ACC_PRES,
        OP_ACC_ABS,
        OP_READ,
        OP_CLEAR,
        OP_RANGE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [AddrW-1:0] addr;
    } t_job;

endpackage

`default_nettype wire

// ===== hw/rtl/group_species_presence_counter_core.sv =====
// top level of the group/species presence counter
`timescale 1ns / 1ps
`default_nettype none

// Counting table of 16 groups by 256 species; each cell holds a 16-bit
// presence count and a 16-bit absence count that saturate at 65535. An
// accumulate item (tuser 0) bumps the presence count for value 1 or the
// absence count for value 0, any other value leaves the cell alone; read
// (tuser 1 or 3) returns the cell, read-and-clear (tuser 2) returns the
// counts before zeroing the cell. Every item gives exactly one result item
// carrying the counts after the step (before zeroing for read-and-clear)
// and a status (0 ok, 1 index beyond the configured group or species count,
// with zero counts, 2 saturated). After reset the block runs a clearing
// pass, one cell per cycle, and takes no item until it ends; configuration
// writes are taken at any time but belong in idle periods. Items flow
// through a front end (range check and decode), a two-entry queue, and a
// back end that does a read then a write on the single-port count memory;
// the back end holds one item at a time through that read-modify-write, its
// write waiting while an untaken result fills the result register. An item
// passes the queue slot, the read data register and the result register;
// that register lets the next item enter while a result waits to be taken.
module group_species_presence_counter_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input items
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // group_index[3:0], species_index[11:4], observed_value[19:12], zero pad
    input  wire logic [gspc_pkg::InDataW-1:0]    s_axis_tdata,
    // cmd[1:0]
    input  wire logic [gspc_pkg::CmdW-1:0]       s_axis_tuser,
    // result items
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // presence_count[15:0], absence_count[31:16]
    output logic [gspc_pkg::OutDataW-1:0]        m_axis_tdata,
    // status[1:0]
    output logic [gspc_pkg::StatusW-1:0]         m_axis_tuser,
    // configuration: index 0 groups_in_use, index 1 species_in_use
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [gspc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [gspc_pkg::CfgDataW-1:0]   i_cfg_data
);
    import gspc_pkg::*;

    t_job              w_push_job;
    t_job              w_pop_job;
    logic              w_push;
    logic              w_pop;
    logic              w_q_full;
    logic              w_q_valid;
    logic              w_busy;
    logic [CountW-1:0] w_pres;
    logic [CountW-1:0] w_abs;

    // split the packed input fields
    gspc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_group     (s_axis_tdata[GroupW-1:0]),
        .i_species   (s_axis_tdata[GroupW+SpeciesW-1:GroupW]),
        .i_value     (s_axis_tdata[InFieldsW-1:GroupW+SpeciesW]),
        .i_busy      (w_busy),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_job       (w_push_job)
    );

    gspc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_job   (w_pop_job)
    );

    gspc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_q_valid),
        .i_job      (w_pop_job),
        .o_pop      (w_pop),
        .o_busy     (w_busy),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_presence (w_pres),
        .o_absence  (w_abs),
        .o_status   (m_axis_tuser)
    );

    // pack result counts, presence in the low half
    assign m_axis_tdata = OutDataW'({w_abs, w_pres});

endmodule

`default_nettype wire

// ===== hw/rtl/gspc_front.sv =====
// front end: configuration registers, range check and command decode
`timescale 1ns / 1ps
`default_nettype none

module gspc_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // configuration writes
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [gspc_pkg::CfgIdxW-1:0] i_cfg_index,
    input  wire logic [gspc_pkg::CfgDataW-1:0] i_cfg_data,
    // incoming item
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [gspc_pkg::CmdW-1:0]    i_cmd,
    input  wire logic [gspc_pkg::GroupW-1:0]  i_group,
    input  wire logic [gspc_pkg::SpeciesW-1:0] i_species,
    input  wire logic [gspc_pkg::ValueW-1:0]  i_value,
    // toward the queue
    input  wire logic                         i_busy,
    input  wire logic                         i_q_full,
    output logic                              o_push,
    output gspc_pkg::t_job                    o_job
);
    import gspc_pkg::*;

    logic [GroupsW-1:0]     r_groups;
    logic [SpeciesLimW-1:0] r_species;
    logic                   w_in_range;
    t_cmd                   w_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_groups  <= GroupsReset;
            r_species <= SpeciesReset;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_GROUPS:  r_groups  <= i_cfg_data[GroupsW-1:0];
                REG_SPECIES: r_species <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // limits above the table size need no clamp: the index can never reach them
    assign w_in_range = ({1'b0, i_group} < r_groups) && ({1'b0, i_species} < r_species);
    assign w_cmd      = t_cmd'(i_cmd);

    assign o_ready = !i_q_full && !i_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_job.addr = {i_group, i_species};
        if (!w_in_range) begin
            o_job.op = OP_RANGE;
        end else begin
            unique case (w_cmd)
                CMD_ACC: begin
                    if (i_value == ValPresent) begin
                        o_job.op = OP_ACC_PRES;
                    end else if (i_value == ValAbsent) begin
                        o_job.op = OP_ACC_ABS;
                    end else begin
                        o_job.op = OP_READ;
                    end
                end
                CMD_READ_CLEAR: o_job.op = OP_CLEAR;
                default:        o_job.op = OP_READ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gspc_queue.sv =====
// two-entry queue of decoded jobs between front and back end
`timescale 1ns / 1ps
`default_nettype none

module gspc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire gspc_pkg::t_job i_job,
    output logic                o_full,
    output logic                o_valid,
    input  wire logic           i_pop,
    output gspc_pkg::t_job      o_job
);
    import gspc_pkg::*;

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gspc_back.sv =====
// back end: count memory, read-modify-write sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

module gspc_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // from the queue
    input  wire logic                          i_q_valid,
    input  wire gspc_pkg::t_job                i_job,
    output logic                               o_pop,
    output logic                               o_busy,
    // result
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [gspc_pkg::CountW-1:0]        o_presence,
    output logic [gspc_pkg::CountW-1:0]        o_absence,
    output logic [gspc_pkg::StatusW-1:0]       o_status
);
    import gspc_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC
    } t_state;

    // each word: presence count high, absence count low
    logic [2*CountW-1:0] r_mem [CellCount];
    logic [2*CountW-1:0] r_rd_data;

    t_state             r_state;
    logic [AddrW-1:0]   r_clr_addr;
    t_job               r_job;
    logic               r_out_valid;
    logic [CountW-1:0]  r_out_pres;
    logic [CountW-1:0]  r_out_abs;
    t_status            r_out_status;

    logic               w_can_load;
    logic               w_load;
    logic               w_wr_en;
    logic [AddrW-1:0]   w_wr_addr;
    logic [2*CountW-1:0] w_wr_data;
    logic [CountW-1:0]  w_old_pres;
    logic [CountW-1:0]  w_old_abs;
    logic [CountW-1:0]  w_res_pres;
    logic [CountW-1:0]  w_res_abs;
    t_status            w_res_status;
    logic               w_upd;

    assign w_old_pres = r_rd_data[2*CountW-1:CountW];
    assign w_old_abs  = r_rd_data[CountW-1:0];
    assign w_can_load = !r_out_valid || i_ready;
    assign w_load     = (r_state == S_CALC) && w_can_load;
    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_busy     = (r_state == S_CLEAR);

    // cell update for the job in hand
    always_comb begin
        w_res_pres   = w_old_pres;
        w_res_abs    = w_old_abs;
        w_res_status = ST_OK;
        w_upd        = 1'b0;
        w_wr_data    = r_rd_data;
        unique case (r_job.op)
            OP_ACC_PRES: begin
                if (w_old_pres == CountMax) begin
                    w_res_status = ST_SAT;
                end else begin
                    w_res_pres = w_old_pres + CountW'(1);
                    w_upd      = 1'b1;
                end
                w_wr_data = {w_res_pres, w_old_abs};
            end
            OP_ACC_ABS: begin
                if (w_old_abs == CountMax) begin
                    w_res_status = ST_SAT;
                end else begin
                    w_res_abs = w_old_abs + CountW'(1);
                    w_upd     = 1'b1;
                end
                w_wr_data = {w_old_pres, w_res_abs};
            end
            OP_CLEAR: begin
                w_upd     = 1'b1;
                w_wr_data = '0;
            end
            OP_RANGE: begin
                w_res_pres   = '0;
                w_res_abs    = '0;
                w_res_status = ST_RANGE;
            end
            default: ;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_clr_addr;
            end
            S_CALC: begin
                w_wr_en   = w_upd && w_can_load;
                w_wr_addr = r_job.addr;
            end
            default: begin
                w_wr_en   = 1'b0;
                w_wr_addr = r_job.addr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= (r_state == S_CLEAR) ? '0 : w_wr_data;
        end
        if (o_pop) begin
            r_rd_data <= r_mem[i_job.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // a new result replaces the one taken this cycle
            r_out_valid <= w_load || (r_out_valid && !i_ready);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AddrW'(1);
                    if (r_clr_addr == AddrW'(CellCount - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_job   <= i_job;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (w_can_load) begin
                        r_out_pres   <= w_res_pres;
                        r_out_abs    <= w_res_abs;
                        r_out_status <= w_res_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid    = r_out_valid;
    assign o_presence = r_out_pres;
    assign o_absence  = r_out_abs;
    assign o_status   = r_out_status;

    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_out_valid)
        else $error("result present during clearing pass");

    a_range_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_RANGE) |-> (r_out_pres == '0 && r_out_abs == '0))
        else $error("range error result with nonzero counts");

    a_sat_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status == ST_SAT) |->
        (r_out_pres == CountMax || r_out_abs == CountMax))
        else $error("saturation flagged below maximum count");

endmodule

`default_nettype wire
